### hdl/pcfa_pkg.sv
// Shared types and constants for the point charge field accumulator.
`default_nettype none
package pcfa_pkg;
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SQRT,
    S_DIV,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_R2,
    PH_NUM,
    PH_CX,
    PH_CY
  } phase_t;

  localparam logic [7:0] REG_COEF_PICO  = 8'd0;
  localparam logic [7:0] REG_COEF_NANO  = 8'd1;
  localparam logic [7:0] REG_COEF_MICRO = 8'd2;
  localparam logic [7:0] REG_COEF_MILLI = 8'd3;
  localparam logic [7:0] REG_COEF_UNIT  = 8'd4;

  localparam logic [2:0] SCALE_PICO  = 3'd0;
  localparam logic [2:0] SCALE_NANO  = 3'd1;
  localparam logic [2:0] SCALE_MICRO = 3'd2;
  localparam logic [2:0] SCALE_MILLI = 3'd3;

  localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX64  = 64'h7FFF_FFFF_FFFF_FFFF;
endpackage
`default_nettype wire

### hdl/point_charge_field_accumulator_core.sv
// Top level: iterative Coulomb field per charge with saturating running sum.
// Steps: a multiply for r^2, a square root, then a multiply and a divide for each
// of magnitude, x, y, then an output state; zero distance goes straight to output.
// New charges are taken only in idle; the shared 128-bit restoring divider serves
// all three quotients. The result waits in an output register while
// the next charge is taken. Reset (rst) clears coefficients, sums and control state.
`default_nettype none
module point_charge_field_accumulator_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] probe_x,
  input  wire logic [31:0] probe_y,
  input  wire logic [31:0] charge_x,
  input  wire logic [31:0] charge_y,
  input  wire logic [31:0] charge_value,
  input  wire logic [2:0]  charge_scale,
  input  wire logic        first,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      field_x,
  output logic [63:0]      field_y,
  output logic [63:0]      field_mag,
  output logic [31:0]      distance,
  output logic [63:0]      total_x,
  output logic [63:0]      total_y,
  output logic             zero_distance,
  output logic             is_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import pcfa_pkg::*;

  state_t state, state_next;
  phase_t phase;
  logic [6:0] cnt;

  logic [63:0] coef_pico, coef_nano, coef_micro, coef_milli, coef_unit;
  logic [63:0] sum_x, sum_y;

  // captured item
  logic [32:0] dxa, dya, qabs;
  logic        dxneg, dyneg, qneg, first_q, last_q;
  logic [63:0] coef;

  logic [127:0] acc;
  logic [65:0]  r2;
  logic [63:0]  rq;
  logic [127:0] sq_n;
  logic [67:0]  rem;
  logic [67:0]  den;
  logic [127:0] dvd, quo;
  logic [63:0]  mag, fx, fy;
  logic         zero_q;

  // input differences
  logic signed [32:0] dx_in, dy_in;
  logic [63:0]        coef_in;
  assign dx_in = $signed({probe_x[31], probe_x}) - $signed({charge_x[31], charge_x});
  assign dy_in = $signed({probe_y[31], probe_y}) - $signed({charge_y[31], charge_y});

  always_comb begin
    case (charge_scale)
      SCALE_PICO:  coef_in = coef_pico;
      SCALE_NANO:  coef_in = coef_nano;
      SCALE_MICRO: coef_in = coef_micro;
      SCALE_MILLI: coef_in = coef_milli;
      default:     coef_in = coef_unit;
    endcase
  end

  // shared multiplier
  logic [63:0] mabs;
  logic [32:0] mul_a, mul_b;
  logic [65:0] prod;
  logic [127:0] prod_sh;

  assign mabs = mag[63] ? (64'd0 - mag) : mag;

  always_comb begin
    case (phase)
      PH_R2: begin
        mul_a = cnt[0] ? dya : dxa;
        mul_b = cnt[0] ? dya : dxa;
      end
      PH_NUM: begin
        mul_a = cnt[0] ? {1'b0, coef[63:32]} : {1'b0, coef[31:0]};
        mul_b = qabs;
      end
      PH_CX: begin
        mul_a = cnt[0] ? {1'b0, mabs[63:32]} : {1'b0, mabs[31:0]};
        mul_b = dxa;
      end
      default: begin
        mul_a = cnt[0] ? {1'b0, mabs[63:32]} : {1'b0, mabs[31:0]};
        mul_b = dya;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign prod_sh = (cnt[0] && phase != PH_R2) ? {30'd0, prod, 32'd0} : {62'd0, prod};

  logic [127:0] acc_sum;
  assign acc_sum = acc + prod_sh;

  // sqrt step
  logic [67:0] sq_rem_s, sq_trial;
  logic        sq_ge;
  assign sq_rem_s = {rem[65:0], sq_n[127:126]};
  assign sq_trial = {2'b00, rq, 2'b01};
  assign sq_ge    = sq_rem_s >= sq_trial;

  // divide step
  logic [67:0] dv_rem_s;
  logic        dv_ge;
  assign dv_rem_s = {rem[66:0], dvd[127]};
  assign dv_ge    = dv_rem_s >= den;

  logic [127:0] quo_next;
  assign quo_next = {quo[126:0], dv_ge};

  // saturation of the finished quotient
  logic        q_sat;
  logic [63:0] q_signed;
  logic        q_neg;
  always_comb begin
    case (phase)
      PH_NUM:  q_neg = qneg;
      PH_CX:   q_neg = mag[63] ^ dxneg;
      default: q_neg = mag[63] ^ dyneg;
    endcase
    q_sat = |quo_next[127:63];
    if (q_sat) q_signed = q_neg ? SIGN64 : MAX64;
    else q_signed = q_neg ? (64'd0 - quo_next[63:0]) : quo_next[63:0];
  end

  logic mul_end, sqrt_end, div_end, out_free;
  assign mul_end  = cnt[0];
  assign sqrt_end = cnt == 7'd63;
  assign div_end  = cnt == 7'd127;
  assign out_free = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_MUL;
      S_MUL: begin
        if (mul_end) begin
          if (phase == PH_R2) state_next = (acc_sum[65:0] == 66'd0) ? S_DONE : S_SQRT;
          else state_next = S_DIV;
        end
      end
      S_SQRT: if (sqrt_end) state_next = S_MUL;
      S_DIV: if (div_end) state_next = (phase == PH_CY) ? S_DONE : S_MUL;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall  = state != S_IDLE;
    cfg_ready = 1'b1;
  end

  // saturating sum
  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) sat_add = a[63] ? SIGN64 : MAX64;
    else sat_add = s;
  endfunction

  logic [63:0] base_x, base_y;
  assign base_x = first_q ? 64'd0 : sum_x;
  assign base_y = first_q ? 64'd0 : sum_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_R2;
      cnt        <= 7'd0;
      out_valid  <= 1'b0;
      sum_x      <= 64'd0;
      sum_y      <= 64'd0;
      coef_pico  <= 64'd0;
      coef_nano  <= 64'd0;
      coef_micro <= 64'd0;
      coef_milli <= 64'd0;
      coef_unit  <= 64'd0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          REG_COEF_PICO:  coef_pico  <= cfg_data;
          REG_COEF_NANO:  coef_nano  <= cfg_data;
          REG_COEF_MICRO: coef_micro <= cfg_data;
          REG_COEF_MILLI: coef_milli <= cfg_data;
          REG_COEF_UNIT:  coef_unit  <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            phase   <= PH_R2;
            cnt     <= 7'd0;
            acc     <= 128'd0;
            dxneg   <= dx_in[32];
            dyneg   <= dy_in[32];
            dxa     <= dx_in[32] ? 33'(-dx_in) : 33'(dx_in);
            dya     <= dy_in[32] ? 33'(-dy_in) : 33'(dy_in);
            qneg    <= charge_value[31];
            qabs    <= charge_value[31] ? (33'd0 - {1'b1, charge_value})
                                        : {1'b0, charge_value};
            coef    <= coef_in;
            first_q <= first;
            last_q  <= last;
            mag     <= 64'd0;
            fx      <= 64'd0;
            fy      <= 64'd0;
            rq      <= 64'd0;
          end
        end
        S_MUL: begin
          acc <= acc_sum;
          cnt <= mul_end ? 7'd0 : cnt + 7'd1;
          if (mul_end) begin
            rem <= 68'd0;
            quo <= 128'd0;
            if (phase == PH_R2) begin
              r2     <= acc_sum[65:0];
              zero_q <= acc_sum[65:0] == 66'd0;
              sq_n   <= {30'd0, acc_sum[65:0], 32'd0};
              rq     <= 64'd0;
            end else begin
              dvd <= {acc_sum[111:0], 16'd0};
              den <= (phase == PH_NUM) ? {2'b00, r2} : {4'd0, rq};
            end
          end
        end
        S_SQRT: begin
          sq_n <= {sq_n[125:0], 2'b00};
          cnt  <= sqrt_end ? 7'd0 : cnt + 7'd1;
          if (sq_ge) begin
            rem <= sq_rem_s - sq_trial;
            rq  <= {rq[62:0], 1'b1};
          end else begin
            rem <= sq_rem_s;
            rq  <= {rq[62:0], 1'b0};
          end
          if (sqrt_end) begin
            phase <= PH_NUM;
            acc   <= 128'd0;
          end
        end
        S_DIV: begin
          dvd <= {dvd[126:0], 1'b0};
          quo <= quo_next;
          rem <= dv_ge ? (dv_rem_s - den) : dv_rem_s;
          cnt <= div_end ? 7'd0 : cnt + 7'd1;
          if (div_end) begin
            acc <= 128'd0;
            case (phase)
              PH_NUM:  begin mag <= q_signed; phase <= PH_CX; end
              PH_CX:   begin fx <= q_signed; phase <= PH_CY; end
              default: fy <= q_signed;
            endcase
          end
        end
        S_DONE: begin
          if (out_free) begin
            field_x       <= fx;
            field_y       <= fy;
            field_mag     <= mag;
            distance      <= (|rq[63:48]) ? 32'hFFFF_FFFF : rq[47:16];
            zero_distance <= zero_q;
            is_last       <= last_q;
            if (zero_q) begin
              sum_x   <= base_x;
              sum_y   <= base_y;
              total_x <= base_x;
              total_y <= base_y;
            end else begin
              sum_x   <= sat_add(base_x, fx);
              sum_y   <= sat_add(base_y, fy);
              total_x <= sat_add(base_x, fx);
              total_y <= sat_add(base_y, fy);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // a charge on the probe contributes nothing
  assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_distance |-> field_x == 64'd0 && field_y == 64'd0 && distance == 32'd0)
    else $error("zero distance result carries a field");

  // busy sequencer holds off new charges
  assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall)
    else $error("charge accepted while busy");

  // output register loads only from the final state
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result shown without completion");

  // sqrt and multiply counters stay in range
  assert property (@(posedge clk) disable iff (rst)
    (state != S_SQRT || cnt < 7'd64) && (state != S_MUL || cnt < 7'd2))
    else $error("step counter out of range");
endmodule
`default_nettype wire

### sim/tb_point_charge_field_accumulator_core.sv
// Testbench for the point charge field accumulator: directed and random charges, scored
`timescale 1ns / 100ps
`default_nettype none
module tb_point_charge_field_accumulator_core;
  import pcfa_pkg::*;

  typedef struct packed {
    logic [63:0] fx;
    logic [63:0] fy;
    logic [63:0] mag;
    logic [31:0] dst;
    logic [63:0] tx;
    logic [63:0] ty;
    logic        zero;
    logic        lst;
  } field_result_t;

  // Coulomb field predictor with its own coefficients and running sums.
  class field_scoreboard;
    logic [63:0] coef [5];
    logic [63:0] acc_x, acc_y;
    field_result_t pending [$];
    int errors;

    function new();
      foreach (coef[i]) coef[i] = '0;
      acc_x = '0;
      acc_y = '0;
      errors = 0;
    endfunction

    function void write_coef(logic [7:0] idx, logic [63:0] val);
      if (idx <= REG_COEF_UNIT) coef[idx] = val;
    endfunction

    function logic [63:0] saturate(logic [127:0] m, logic neg);
      if (m > {64'd0, MAX64}) return neg ? SIGN64 : MAX64;
      return neg ? -m[63:0] : m[63:0];
    endfunction

    function logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) return a[63] ? SIGN64 : MAX64;
      return s;
    endfunction

    function logic [63:0] isqrt(logic [127:0] n);
      logic [63:0] root, c;
      root = '0;
      for (int b = 63; b >= 0; b--) begin
        c = root | (64'd1 << b);
        if ({64'd0, c} * {64'd0, c} <= n) root = c;
      end
      return root;
    endfunction

    function logic [63:0] project(logic [63:0] mag, logic signed [63:0] d, logic [63:0] rq);
      logic [63:0] ma, da;
      logic [127:0] num;
      ma = mag[63] ? -mag : mag;
      da = d[63] ? -d : d;
      num = ({64'd0, ma} * {64'd0, da}) << 16;
      return saturate(num / {64'd0, rq}, mag[63] != d[63]);
    endfunction

    function void note_charge(logic [31:0] px, logic [31:0] py, logic [31:0] cx,
                              logic [31:0] cy, logic [31:0] qv, logic [2:0] sc,
                              logic fst, logic lst);
      logic signed [63:0] dx, dy, q;
      logic [63:0] adx, ady, aq, c, rq;
      logic [127:0] r2, num;
      field_result_t r;
      dx = $signed({{32{px[31]}}, px}) - $signed({{32{cx[31]}}, cx});
      dy = $signed({{32{py[31]}}, py}) - $signed({{32{cy[31]}}, cy});
      q = $signed({{32{qv[31]}}, qv});
      adx = dx[63] ? -dx : dx;
      ady = dy[63] ? -dy : dy;
      aq = q[63] ? -q : q;
      c = (sc > SCALE_MILLI) ? coef[REG_COEF_UNIT] : coef[sc];
      r2 = {64'd0, adx} * {64'd0, adx} + {64'd0, ady} * {64'd0, ady};
      r = '0;
      if (fst) begin
        acc_x = '0;
        acc_y = '0;
      end
      r.zero = (r2 == 0);
      if (!r.zero) begin
        rq = isqrt(r2 << 32);
        num = ({64'd0, c} * {64'd0, aq}) << 16;
        r.mag = saturate(num / r2, q[63]);
        r.dst = (rq >> 16 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rq[47:16];
        r.fx = project(r.mag, dx, rq);
        r.fy = project(r.mag, dy, rq);
        acc_x = add_sat(acc_x, r.fx);
        acc_y = add_sat(acc_y, r.fy);
      end
      r.tx = acc_x;
      r.ty = acc_y;
      r.lst = lst;
      pending = {pending, r};
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    task check_result(field_result_t got);
      field_result_t w;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", 64'd0, 64'd0);
        return;
      end
      w = pending.pop_front();
      if (got.fx !== w.fx) report_mismatch("field_x", got.fx, w.fx);
      if (got.fy !== w.fy) report_mismatch("field_y", got.fy, w.fy);
      if (got.mag !== w.mag) report_mismatch("field_mag", got.mag, w.mag);
      if (got.dst !== w.dst) report_mismatch("distance", 64'(got.dst), 64'(w.dst));
      if (got.tx !== w.tx) report_mismatch("total_x", got.tx, w.tx);
      if (got.ty !== w.ty) report_mismatch("total_y", got.ty, w.ty);
      if (got.zero !== w.zero)
        report_mismatch("zero_distance", 64'(got.zero), 64'(w.zero));
      if (got.lst !== w.lst) report_mismatch("is_last", 64'(got.lst), 64'(w.lst));
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall;
  logic [31:0] probe_x = 0, probe_y = 0, charge_x = 0, charge_y = 0, charge_value = 0;
  logic [2:0] charge_scale = 0;
  logic first = 0, last = 0;
  logic out_valid, out_stall = 0;
  logic [63:0] field_x, field_y, field_mag, total_x, total_y;
  logic [31:0] distance;
  logic zero_distance, is_last;
  logic cfg_valid = 0, cfg_ready;
  logic [7:0] cfg_index = 0;
  logic [63:0] cfg_data = 0;

  field_scoreboard board;
  int hold_cycles = 0;
  bit calm = 0;

  point_charge_field_accumulator_core dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Drain side: random stalls, long hold-offs on request.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result({field_x, field_y, field_mag, distance, total_x, total_y,
                          zero_distance, is_last});
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 31);
  end

  task automatic write_coef(logic [7:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_coef(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic send_charge(logic [31:0] px, logic [31:0] py, logic [31:0] cx,
                             logic [31:0] cy, logic [31:0] qv, logic [2:0] sc,
                             logic fst, logic lst);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 31) @(negedge clk);
    in_valid <= 1;
    probe_x <= px; probe_y <= py; charge_x <= cx; charge_y <= cy;
    charge_value <= qv; charge_scale <= sc; first <= fst; last <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_charge(px, py, cx, cy, qv, sc, fst, lst);
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_coefs(int mode);
    for (int i = 0; i <= REG_COEF_UNIT; i++)
      case (mode)
        0: write_coef(i[7:0], 64'd0);
        1: write_coef(i[7:0], 64'hFFFF_FFFF_FFFF_FFFF);
        2: write_coef(i[7:0], {$urandom_range(255), 32'h0} >> (3 * i));
        default: write_coef(i[7:0], {$urandom, $urandom});
      endcase
    write_coef(REG_COEF_UNIT + 8'd1, {$urandom, $urandom});
  endtask

  task automatic random_charges(int n);
    logic [31:0] px, py, cx, cy, qv;
    int k;
    k = 0;
    while (k < n) begin
      px = $urandom; py = $urandom;
      for (int j = 0; j < $urandom_range(1, 6) && k < n; j++, k++) begin
        case ($urandom_range(5))
          0: begin cx = px; cy = py; end
          1: begin cx = px + $urandom_range(3) - 1; cy = py + $urandom_range(3) - 1; end
          2: begin cx = px + ($urandom >> 12); cy = py - ($urandom >> 12); end
          default: begin cx = $urandom; cy = $urandom; end
        endcase
        qv = ($urandom_range(3) == 0) ? $urandom : ($urandom >> $urandom_range(31));
        if ($urandom_range(1)) qv = -qv;
        send_charge(px, py, cx, cy, qv, 3'($urandom_range(7)),
                    j == 0 || $urandom_range(15) == 0, $urandom_range(3) == 0);
      end
    end
  endtask

  initial begin
    board = new();
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 0;
    set_coefs(2);
    // directed: extremes, coincident charge, every scale code, first on zero distance
    send_charge(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 3'd0, 1, 0);
    send_charge(0, 0, 0, 0, 32'h7FFF_FFFF, 3'd4, 1, 1);
    send_charge(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 3'd4, 0, 0);
    send_charge(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 3'd7, 0, 1);
    for (int s = 0; s < 8; s++)
      send_charge(0, 0, 32'hFFFF_0000 + s, 32'h0000_8000, 32'hFFFF_FFFF, s[2:0], s == 0, s == 7);
    send_charge(0, 0, 0, 1, 32'h7FFF_FFFF, 3'd4, 1, 0);
    send_charge(5, 7, 5, 7, 32'h1234, 3'd2, 0, 1);
    drain();
    set_coefs(1);
    // saturate the running sums with tiny distances and big charges
    for (int i = 0; i < 6; i++)
      send_charge(0, 0, 32'd1, 0, 32'h7FFF_FFFF, 3'd4, i == 0, 0);
    for (int i = 0; i < 4; i++)
      send_charge(0, 0, 0, 32'hFFFF_FFFF, 32'h8000_0000, 3'd4, 0, i == 3);
    drain();
    set_coefs(0);
    random_charges(60);
    drain();
    set_coefs(3);
    random_charges(250);
    // long receiver hold-off while charges keep coming
    hold_cycles = 3000;
    random_charges(20);
    calm = 1;
    random_charges(150);
    calm = 0;
    drain();
    set_coefs(2);
    random_charges(450);
    drain();
    if (board.errors == 0)
      $display("tb_point_charge_field_accumulator_core OK");
    else
      $display("tb_point_charge_field_accumulator_core NOT OK");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("tb_point_charge_field_accumulator_core NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
